FILE: sv/counting_semaphore_wait_queue_defines.svh
// ----------------------------------------------------------------------------
// Counting semaphore wait queue: assertion macros
// Assertion macros shared by the RTL. They expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define CSQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CSQ_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CSQ_ASSERT(name, prop, msg)
`define CSQ_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: sv/csq_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue package
// Shared widths, request and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package csq_pkg;

   localparam int QUEUE_DEPTH_DEF    = 16;
   localparam int THREAD_ID_BITS_DEF = 8;

   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 16;
   localparam int COUNT_W  = 17;

   localparam logic [REQ_W-1:0] REQ_WAIT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SIGNAL = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DEACT  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_PASSED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BLOCKED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_WAITER   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_WOKEN       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEACTIVATED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REFUSED     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd6;
   localparam logic [STATUS_W-1:0] ST_SATURATED   = 3'd7;

   localparam logic signed [COUNT_W-1:0] COUNT_TOP    = 17'sh0FFFF;
   localparam logic signed [COUNT_W-1:0] COUNT_BOTTOM = 17'sh10000;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic                capture;
      logic                dec_count;
      logic                inc_count;
      logic                enqueue;
      logic                dequeue;
      logic                clear_active;
      logic                out_valid;
      logic [STATUS_W-1:0] out_status;
      logic                out_last;
      logic                out_use_id;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_bottom;
      logic count_top;
      logic count_nonpos;
      logic count_neg;
      logic queue_full;
      logic queue_empty;
      logic active;
   } dp_status_type;

endpackage

FILE: sv/csq_ctrl.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue controller
// Decodes each request against the datapath status and sequences the drain.
// ----------------------------------------------------------------------------
module csq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [csq_pkg::REQ_W-1:0] req_type,
   input  csq_pkg::dp_status_type dp_status,
   output csq_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);
   import csq_pkg::*;

   state_type        state_ff, state_in;
   logic [REQ_W-1:0] req_type_ff, req_type_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      req_type_in = req_type_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               req_type_in = req_type;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (req_type_ff)
               REQ_WAIT: begin
                  cmd.out_valid = 1'b1;
                  cmd.out_last  = 1'b1;
                  if (dp_status.count_bottom) begin
                     cmd.out_status = ST_FULL;
                  end else if (dp_status.count_nonpos) begin
                     if (dp_status.queue_full) begin
                        cmd.out_status = ST_FULL;
                     end else begin
                        cmd.dec_count  = 1'b1;
                        cmd.enqueue    = 1'b1;
                        cmd.out_status = ST_BLOCKED;
                     end
                  end else begin
                     cmd.dec_count  = 1'b1;
                     cmd.out_status = ST_PASSED;
                  end
               end
               REQ_SIGNAL: begin
                  cmd.out_valid = 1'b1;
                  cmd.out_last  = 1'b1;
                  if (dp_status.count_top) begin
                     cmd.out_status = ST_SATURATED;
                  end else begin
                     cmd.inc_count = 1'b1;
                     if (!dp_status.count_neg) begin
                        cmd.out_status = ST_PASSED;
                     end else if (dp_status.queue_empty) begin
                        cmd.out_status = ST_NO_WAITER;
                     end else begin
                        cmd.dequeue    = 1'b1;
                        cmd.out_use_id = 1'b1;
                        cmd.out_status = ST_WOKEN;
                     end
                  end
               end
               REQ_DEACT: begin
                  if (!dp_status.active) begin
                     cmd.out_valid  = 1'b1;
                     cmd.out_last   = 1'b1;
                     cmd.out_status = ST_REFUSED;
                  end else begin
                     cmd.clear_active = 1'b1;
                     state_in         = S_DRAIN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_DRAIN: begin
            cmd.out_valid = 1'b1;
            if (dp_status.queue_empty) begin
               cmd.out_status = ST_DEACTIVATED;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.dequeue    = 1'b1;
               cmd.out_use_id = 1'b1;
               cmd.out_status = ST_WOKEN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/csq_dp.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue datapath
// Holds the count, the active flag, the id queue and the result registers.
// ----------------------------------------------------------------------------
`include "counting_semaphore_wait_queue_defines.svh"

module csq_dp #(
   parameter int QUEUE_DEPTH    = csq_pkg::QUEUE_DEPTH_DEF,
   parameter int THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [THREAD_ID_BITS-1:0]    req_thread_id,
   input  logic                         csr_wr_en,
   input  logic [csq_pkg::CFG_W-1:0]    csr_wr_data,
   input  csq_pkg::ctrl_cmd_type        cmd,
   output csq_pkg::dp_status_type       dp_status,
   output logic                         rsp_strobe,
   output logic [csq_pkg::STATUS_W-1:0] rsp_status,
   output logic [THREAD_ID_BITS-1:0]    rsp_woken_id,
   output logic                         rsp_last
);
   import csq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic                      active_ff, active_in;
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [PTR_W-1:0]          tail_ff, tail_in;
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic [THREAD_ID_BITS-1:0] id_ff;
   logic [THREAD_ID_BITS-1:0] rd_data_ff;
   logic                      strobe_ff;
   logic [STATUS_W-1:0]       status_ff;
   logic [THREAD_ID_BITS-1:0] woken_ff;
   logic                      last_ff;
   logic [THREAD_ID_BITS-1:0] queue_mem [QUEUE_DEPTH];

   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         count_in = signed'({1'b0, csr_wr_data});
      end else if (cmd.dec_count) begin
         count_in = count_ff - 17'sd1;
      end else if (cmd.inc_count) begin
         count_in = count_ff + 17'sd1;
      end
   end

   assign active_in = active_ff & ~cmd.clear_active;
   assign head_in   = !cmd.dequeue ? head_ff :
                      (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_in   = !cmd.enqueue ? tail_ff :
                      (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;

   always_comb begin
      occ_in = occ_ff;
      if (cmd.enqueue && !cmd.dequeue) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd.dequeue && !cmd.enqueue) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b1;
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         strobe_ff <= cmd.out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         id_ff <= req_thread_id;
      end
      if (cmd.out_valid) begin
         status_ff <= cmd.out_status;
         last_ff   <= cmd.out_last;
         woken_ff  <= cmd.out_use_id ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enqueue) begin
         queue_mem[tail_ff] <= id_ff;
      end
      rd_data_ff <= queue_mem[head_in];
   end

   always_comb begin
      dp_status.count_bottom = (count_ff == COUNT_BOTTOM);
      dp_status.count_top    = (count_ff == COUNT_TOP);
      dp_status.count_nonpos = (count_ff <= 17'sd0);
      dp_status.count_neg    = (count_ff < 17'sd0);
      dp_status.queue_full   = (occ_ff >= OCC_FULL);
      dp_status.queue_empty  = (occ_ff == '0);
      dp_status.active       = active_ff;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_woken_id = woken_ff;
   assign rsp_last     = last_ff;

   `CSQ_ASSERT(a_occ_bound, (occ_ff <= OCC_FULL), "Queue occupancy exceeds its depth.")
   `CSQ_ASSERT(a_no_enq_full, (cmd.enqueue |-> !dp_status.queue_full), "Enqueue on a full queue.")
   `CSQ_ASSERT(a_no_deq_empty, (cmd.dequeue |-> !dp_status.queue_empty), "Dequeue on an empty queue.")
   `CSQ_ASSERT(a_ptr_match, ((head_ff == tail_ff) == ((occ_ff == '0) || (occ_ff == OCC_FULL))), "Queue pointers disagree with occupancy.")
   `CSQ_ASSERT_ALWAYS(a_reset_idle, ($past(reset) |-> !rsp_strobe), "Result strobe right after reset.")

endmodule

FILE: sv/counting_semaphore_wait_queue.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue
// Counting semaphore with a FIFO of blocked thread ids.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Wait and signal
// requests each pass through the transfer cycle and the execute cycle, with
// the result on the rsp_ ports for one cycle right after the execute cycle. A
// deactivate of an active semaphore passes through the transfer cycle, the
// execute cycle and the drain, which reads one id per cycle from the queue
// memory and issues one transfer per id, followed by the done result. The
// receiver cannot stall, so every strobed result must be taken in the cycle
// it appears. A csr_ write loads the count and must only happen while the
// block is not busy.
`include "counting_semaphore_wait_queue_defines.svh"

module counting_semaphore_wait_queue #(
   parameter int QUEUE_DEPTH    = csq_pkg::QUEUE_DEPTH_DEF,
   parameter int THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [csq_pkg::REQ_W-1:0]    req_type,
   input  logic [THREAD_ID_BITS-1:0]    req_thread_id,
   output logic                         rsp_strobe,
   output logic [csq_pkg::STATUS_W-1:0] rsp_status,
   output logic [THREAD_ID_BITS-1:0]    rsp_woken_id,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [csq_pkg::CFG_W-1:0]    csr_wr_data
);
   import csq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   csq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   csq_dp #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_thread_id (req_thread_id),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .dp_status     (dp_status),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_woken_id  (rsp_woken_id),
      .rsp_last      (rsp_last)
   );

   `CSQ_ASSERT(a_woken_not_last_only_drain, ((rsp_strobe && !rsp_last) |-> (rsp_status == ST_WOKEN)), "A non-final result is not a woken id.")
   `CSQ_ASSERT(a_capture_when_free, (cmd.capture |-> (start && !busy)), "Request captured while busy.")
   `CSQ_ASSERT(a_busy_after_accept, ((start && !busy) |=> busy), "Busy not raised after a request transfer.")

endmodule
